>>> hdl/rpcm_pkg.sv
// Package with shared types, codes and constants of the raw PCM to s16 converter.
`timescale 1ns / 1ps
`default_nettype none

package rpcm_pkg;

    localparam int unsigned AddrWidth = 5;
    localparam int unsigned DataWidth = 32;

    localparam logic [2:0] REG_SAMPLE_RATE   = 3'd0;
    localparam logic [2:0] REG_CHANNEL_COUNT = 3'd1;
    localparam logic [2:0] REG_SAMPLE_FORMAT = 3'd2;
    localparam logic [2:0] REG_BYTE_LENGTH   = 3'd3;
    localparam logic [2:0] REG_LOOP_START    = 3'd4;
    localparam logic [2:0] REG_LOOP_END      = 3'd5;

    localparam logic [1:0] STATUS_OK          = 2'd0;
    localparam logic [1:0] STATUS_UNSUPPORTED = 2'd1;
    localparam logic [1:0] STATUS_MALFORMED   = 2'd2;

    localparam logic signed [6:0] FMT_U8   = 7'sd8;
    localparam logic signed [6:0] FMT_S8   = -7'sd8;
    localparam logic signed [6:0] FMT_P16  = 7'sd16;
    localparam logic signed [6:0] FMT_N16  = -7'sd16;
    localparam logic signed [6:0] FMT_P32  = 7'sd32;
    localparam logic signed [6:0] FMT_N32  = -7'sd32;

    localparam logic [1:0] BPS_LOG_1 = 2'd0;
    localparam logic [1:0] BPS_LOG_2 = 2'd1;
    localparam logic [1:0] BPS_LOG_4 = 2'd2;

    localparam logic [7:0] UNSIGNED_FLIP = 8'h80;

    localparam logic [31:0]       RESET_SAMPLE_RATE   = 32'd0;
    localparam logic [7:0]        RESET_CHANNEL_COUNT = 8'd1;
    localparam logic signed [6:0] RESET_SAMPLE_FORMAT = 7'sd16;
    localparam logic [31:0]       RESET_BYTE_LENGTH   = 32'd0;
    localparam logic [31:0]       RESET_LOOP_START    = 32'hffff_ffff;
    localparam logic [31:0]       RESET_LOOP_END      = 32'hffff_ffff;

    typedef struct packed {
        logic [1:0]  status;
        logic [1:0]  bps_log;
        logic        signed8;
        logic [31:0] frames;
        logic        looped;
        logic [31:0] lstart;
        logic [31:0] lend;
    } cfg_eval_t;

endpackage

`default_nettype wire

>>> hdl/raw_pcm_to_s16_converter.sv
// Top level of the raw PCM byte stream to signed 16-bit sample converter.
//
//  Channel   Direction  Handshake               Payload
//  input     in         in_valid / in_ready     data_byte
//  output    out        out_valid / out_ready   sample_value, sample_valid, status,
//                                               last_sample, has_loop, loop_start_frame,
//                                               loop_end_frame, frame_count
//  config    in         APB psel / penable      paddr, pwrite, pwdata, prdata, pready
//
// One byte is accepted per clock cycle while in_ready is high; its result is valid once the
// byte has moved from the input register into the result register.
// The configuration check is registered once per cycle from the register file.
// Reset returns the registers to their defaults and empties both stages.
// While out_ready is low the result holds and one more item waits in the input register.
`timescale 1ns / 1ps
`default_nettype none

module raw_pcm_to_s16_converter
    import rpcm_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,

    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic [7:0]           data_byte,

    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic signed [15:0]        sample_value,
    output logic                      sample_valid,
    output logic [1:0]                status,
    output logic                      last_sample,
    output logic                      has_loop,
    output logic [31:0]               loop_start_frame,
    output logic [31:0]               loop_end_frame,
    output logic [31:0]               frame_count,

    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [AddrWidth-1:0] paddr,
    input  wire logic [DataWidth-1:0] pwdata,
    output logic [DataWidth-1:0]      prdata,
    output logic                      pready
);

    logic [31:0]       sample_rate_reg;
    logic [7:0]        channel_count_reg;
    logic signed [6:0] sample_format_reg;
    logic [31:0]       byte_length_reg;
    logic [31:0]       loop_start_reg;
    logic [31:0]       loop_end_reg;

    logic       cfg_write;
    logic [2:0] cfg_index;

    cfg_eval_t eval_reg;
    cfg_eval_t eval_next;

    logic       s1_valid_reg;
    logic       s1_valid_next;
    logic [7:0] s1_byte_reg;

    logic [1:0]  byte_phase_reg;
    logic [1:0]  byte_phase_next;
    logic [7:0]  held_low_byte_reg;
    logic [7:0]  held_low_byte_next;
    logic [32:0] bytes_seen_reg;
    logic [32:0] bytes_seen_next;

    logic              out_valid_reg;
    logic signed [15:0] sample_value_reg;
    logic              sample_valid_reg;
    logic [1:0]        status_reg;
    logic              last_sample_reg;
    logic              has_loop_reg;
    logic [31:0]       loop_start_frame_reg;
    logic [31:0]       loop_end_frame_reg;
    logic [31:0]       frame_count_reg;

    logic              advance;
    logic              step;
    logic              produce;
    logic              state_update;
    logic signed [15:0] res_value;
    logic              res_valid;
    logic [1:0]        res_status;
    logic              res_last;
    logic              res_loop;
    logic [31:0]       res_lstart;
    logic [31:0]       res_lend;
    logic [31:0]       res_frames;

    // Configuration port.

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_index = paddr[AddrWidth-1:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_rate_reg   <= RESET_SAMPLE_RATE;
            channel_count_reg <= RESET_CHANNEL_COUNT;
            sample_format_reg <= RESET_SAMPLE_FORMAT;
            byte_length_reg   <= RESET_BYTE_LENGTH;
            loop_start_reg    <= RESET_LOOP_START;
            loop_end_reg      <= RESET_LOOP_END;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_SAMPLE_RATE:   sample_rate_reg   <= pwdata;
                REG_CHANNEL_COUNT: channel_count_reg <= pwdata[7:0];
                REG_SAMPLE_FORMAT: sample_format_reg <= signed'(pwdata[6:0]);
                REG_BYTE_LENGTH:   byte_length_reg   <= pwdata;
                REG_LOOP_START:    loop_start_reg    <= pwdata;
                REG_LOOP_END:      loop_end_reg      <= pwdata;
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_index)
            REG_SAMPLE_RATE:   prdata = sample_rate_reg;
            REG_CHANNEL_COUNT: prdata = {24'd0, channel_count_reg};
            REG_SAMPLE_FORMAT: prdata = {25'd0, sample_format_reg};
            REG_BYTE_LENGTH:   prdata = byte_length_reg;
            REG_LOOP_START:    prdata = loop_start_reg;
            REG_LOOP_END:      prdata = loop_end_reg;
            default:           prdata = '0;
        endcase
    end

    // Configuration check, registered every cycle.

    always_comb
    begin
        logic        fmt_ok;
        logic        chan_ok;
        logic        chan2;
        logic [1:0]  bps_log;
        logic [1:0]  shift;
        logic        rem_bad;
        logic [31:0] frames;
        logic        ls_neg;
        logic        le_neg;
        logic        le_to_end;
        logic [31:0] le_eff;
        logic        loop_err;

        eval_next = '0;
        fmt_ok  = (sample_format_reg == FMT_U8) || (sample_format_reg == FMT_S8) ||
                  (sample_format_reg == FMT_P16) || (sample_format_reg == FMT_N16) ||
                  (sample_format_reg == FMT_P32) || (sample_format_reg == FMT_N32);
        chan_ok = (channel_count_reg == 8'd1) || (channel_count_reg == 8'd2);
        chan2   = (channel_count_reg == 8'd2);

        if ((sample_format_reg == FMT_U8) || (sample_format_reg == FMT_S8))
        begin
            bps_log = BPS_LOG_1;
        end
        else if ((sample_format_reg == FMT_P16) || (sample_format_reg == FMT_N16))
        begin
            bps_log = BPS_LOG_2;
        end
        else
        begin
            bps_log = BPS_LOG_4;
        end

        shift = bps_log + {1'b0, chan2};
        unique case (shift)
            2'd0:    rem_bad = 1'b0;
            2'd1:    rem_bad = byte_length_reg[0];
            2'd2:    rem_bad = |byte_length_reg[1:0];
            default: rem_bad = |byte_length_reg[2:0];
        endcase
        frames = byte_length_reg >> shift;

        ls_neg    = loop_start_reg[31];
        le_neg    = loop_end_reg[31];
        le_to_end = !ls_neg && (loop_end_reg == 32'hffff_ffff);
        le_eff    = le_to_end ? frames : loop_end_reg;
        loop_err  = ls_neg || (le_neg && !le_to_end) || (loop_start_reg >= frames) ||
                    (le_eff > frames) || (loop_start_reg >= le_eff);

        eval_next.bps_log = bps_log;
        eval_next.signed8 = (sample_format_reg == FMT_S8);

        if ((sample_rate_reg == 32'd0) || !chan_ok || !fmt_ok)
        begin
            eval_next.status = STATUS_UNSUPPORTED;
        end
        else if ((byte_length_reg == 32'd0) || rem_bad)
        begin
            eval_next.status = STATUS_MALFORMED;
        end
        else if (ls_neg && le_neg)
        begin
            eval_next.status = STATUS_OK;
            eval_next.frames = frames;
        end
        else if (loop_err)
        begin
            eval_next.status = STATUS_MALFORMED;
        end
        else
        begin
            eval_next.status = STATUS_OK;
            eval_next.frames = frames;
            eval_next.looped = 1'b1;
            eval_next.lstart = loop_start_reg;
            eval_next.lend   = le_eff;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eval_reg <= '0;
        end
        else
        begin
            eval_reg <= eval_next;
        end
    end

    // Input register.

    assign advance  = !out_valid_reg || out_ready;
    assign in_ready = !s1_valid_reg || advance;
    assign step     = s1_valid_reg && advance;

    always_comb
    begin
        if (in_valid && in_ready)
        begin
            s1_valid_next = 1'b1;
        end
        else if (advance)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_byte_reg <= data_byte;
        end
    end

    // Sample assembly.

    always_comb
    begin
        logic [1:0]  bps_mask;
        logic [1:0]  phase;
        logic        overrun;
        logic [32:0] seen;

        bps_mask = 2'b00;
        unique case (eval_reg.bps_log)
            BPS_LOG_1: bps_mask = 2'b00;
            BPS_LOG_2: bps_mask = 2'b01;
            default:   bps_mask = 2'b11;
        endcase
        phase   = byte_phase_reg & bps_mask;
        overrun = bytes_seen_reg >= {1'b0, byte_length_reg};
        seen    = bytes_seen_reg + 33'd1;

        byte_phase_next    = (phase + 2'd1) & bps_mask;
        held_low_byte_next = held_low_byte_reg;
        bytes_seen_next    = seen;
        state_update       = 1'b0;

        produce    = 1'b0;
        res_value  = '0;
        res_valid  = 1'b0;
        res_status = eval_reg.status;
        res_last   = 1'b0;
        res_loop   = eval_reg.looped;
        res_lstart = eval_reg.lstart;
        res_lend   = eval_reg.lend;
        res_frames = eval_reg.frames;

        if (eval_reg.status != STATUS_OK)
        begin
            produce    = 1'b1;
            res_loop   = 1'b0;
            res_lstart = '0;
            res_lend   = '0;
            res_frames = '0;
        end
        else if (overrun)
        begin
            produce    = 1'b1;
            res_status = STATUS_MALFORMED;
        end
        else
        begin
            state_update = 1'b1;
            res_last     = (seen == {1'b0, byte_length_reg});
            if (eval_reg.bps_log == BPS_LOG_1)
            begin
                produce   = 1'b1;
                res_valid = 1'b1;
                res_value = eval_reg.signed8 ? signed'({s1_byte_reg, 8'd0})
                                             : signed'({s1_byte_reg ^ UNSIGNED_FLIP, 8'd0});
            end
            else if (phase == bps_mask - 2'd1)
            begin
                held_low_byte_next = s1_byte_reg;
            end
            else if (phase == bps_mask)
            begin
                produce   = 1'b1;
                res_valid = 1'b1;
                res_value = signed'({s1_byte_reg, held_low_byte_reg});
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_phase_reg    <= '0;
            held_low_byte_reg <= '0;
            bytes_seen_reg    <= '0;
        end
        else if (cfg_write && (cfg_index <= REG_LOOP_END))
        begin
            byte_phase_reg    <= '0;
            held_low_byte_reg <= '0;
            bytes_seen_reg    <= '0;
        end
        else if (step && state_update)
        begin
            byte_phase_reg    <= byte_phase_next;
            held_low_byte_reg <= held_low_byte_next;
            bytes_seen_reg    <= bytes_seen_next;
        end
    end

    // Result register.

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= s1_valid_reg && produce;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && produce)
        begin
            sample_value_reg     <= res_value;
            sample_valid_reg     <= res_valid;
            status_reg           <= res_status;
            last_sample_reg      <= res_last;
            has_loop_reg         <= res_loop;
            loop_start_frame_reg <= res_lstart;
            loop_end_frame_reg   <= res_lend;
            frame_count_reg      <= res_frames;
        end
    end

    assign out_valid        = out_valid_reg;
    assign sample_value     = sample_value_reg;
    assign sample_valid     = sample_valid_reg;
    assign status           = status_reg;
    assign last_sample      = last_sample_reg;
    assign has_loop         = has_loop_reg;
    assign loop_start_frame = loop_start_frame_reg;
    assign loop_end_frame   = loop_end_frame_reg;
    assign frame_count      = frame_count_reg;

endmodule

`default_nettype wire

>>> hdl/rpcm_checker.sv
// Port-level checker of the raw PCM to s16 converter and its bind statement.
`timescale 1ns / 1ps
`default_nettype none

module rpcm_checker
    import rpcm_pkg::*;
(
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               out_valid,
    input wire logic               out_ready,
    input wire logic signed [15:0] sample_value,
    input wire logic               sample_valid,
    input wire logic [1:0]         status,
    input wire logic               has_loop,
    input wire logic [31:0]        loop_start_frame,
    input wire logic [31:0]        loop_end_frame,
    input wire logic [31:0]        frame_count
);

    // A stalled item keeps its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(sample_value) && $stable(status))
        else $error("stalled output item changed");

    // A failed item carries no sample.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != STATUS_OK) |-> !sample_valid && (sample_value == 16'sd0))
        else $error("error item carries a sample");

    // An unsupported item reports no buffer geometry.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == STATUS_UNSUPPORTED) |-> !has_loop && (frame_count == 32'd0))
        else $error("unsupported item reports geometry");

    // Loop bounds only appear with a loop; then start < end <= frame count.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !has_loop |-> (loop_start_frame == 32'd0) && (loop_end_frame == 32'd0))
        else $error("loop bounds without a loop");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && has_loop |-> (loop_start_frame < loop_end_frame) &&
                                  (loop_end_frame <= frame_count))
        else $error("loop bounds out of order");

endmodule

bind raw_pcm_to_s16_converter rpcm_checker u_rpcm_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .sample_value     (sample_value),
    .sample_valid     (sample_valid),
    .status           (status),
    .has_loop         (has_loop),
    .loop_start_frame (loop_start_frame),
    .loop_end_frame   (loop_end_frame),
    .frame_count      (frame_count)
);

`default_nettype wire
